// File: rtl/stereo_left_right_check_assert.svh
// assertion macros shared by the stereo left-right check modules
// each use expects clk and rst_n in scope
`ifndef STEREO_LEFT_RIGHT_CHECK_ASSERT_SVH
`define STEREO_LEFT_RIGHT_CHECK_ASSERT_SVH

// property must hold at every edge outside reset
`define SLRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen outside reset
`define SLRC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/slrc_pkg.sv
`timescale 1ns / 1ps

package slrc_pkg;

    // sizes of the row store and the fixed-point format
    localparam int MAX_WIDTH     = 2048;
    localparam int FRACTION_BITS = 4;

    // field widths
    localparam int COL_W       = 11;
    localparam int DISP_W      = 13;
    localparam int MD_W        = 8;
    localparam int ROW_W       = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 2;

    // derived sizes
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int SCALE  = 1 << FRACTION_BITS;
    localparam int HALF   = SCALE >> 1;
    // column * scale - disparity, signed
    localparam int V_W    = ((COL_W + FRACTION_BITS) > DISP_W ?
                             (COL_W + FRACTION_BITS) : DISP_W) + 1;
    // effective row width, clamped to the store depth
    localparam int WEFF_W = (ROW_W > ADDR_W + 1) ? ROW_W : ADDR_W + 1;
    // tolerance and disparity compare
    localparam int TOL_W  = MD_W + FRACTION_BITS;
    localparam int CMP_W  = ((TOL_W > DISP_W) ? TOL_W : DISP_W) + 2;

    // minus one pixel marks an invalid disparity
    localparam logic signed [DISP_W-1:0] INVALID_DISP = DISP_W'(-SCALE);

    // queue between front and back, power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_ENABLE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DIFFERENCE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_WIDTH      = 2'd2;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_CHECK = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_KEPT      = 2'd0,
        STATUS_OCCLUSION = 2'd1,
        STATUS_MISMATCH  = 2'd2,
        STATUS_INVALID   = 2'd3
    } status_t;

    // what the back end has to do with a check item
    typedef enum logic [1:0] {
        CLS_KEEP       = 2'd0,
        CLS_INVALID_IN = 2'd1,
        CLS_OUT_OF_ROW = 2'd2,
        CLS_COMPARE    = 2'd3
    } check_class_t;

    typedef struct packed {
        logic                     check_enable;
        logic [MD_W-1:0]          max_difference;
        logic [ROW_W-1:0]         row_width;
    } slrc_cfg_t;

    typedef struct packed {
        logic [COL_W-1:0]         column;
        logic signed [DISP_W-1:0] disp;
        logic signed [DISP_W-1:0] right_disp;
        check_class_t             cls;
    } slrc_entry_t;

endpackage

// File: rtl/slrc_in_if.sv
`timescale 1ns / 1ps

interface slrc_in_if
    import slrc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [COL_W-1:0]         column;
    logic signed [DISP_W-1:0] disparity_in;

    modport source (output valid, output op, output column, output disparity_in,
                    input ready);
    modport sink   (input valid, input op, input column, input disparity_in,
                    output ready);
endinterface

// File: rtl/slrc_out_if.sv
`timescale 1ns / 1ps

interface slrc_out_if
    import slrc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [COL_W-1:0]         column_out;
    logic signed [DISP_W-1:0] disparity_out;
    logic [1:0]               status;

    modport source (output valid, output column_out, output disparity_out,
                    output status, input ready);
    modport sink   (input valid, input column_out, input disparity_out,
                    input status, output ready);
endinterface

// File: rtl/slrc_ram.sv
`timescale 1ns / 1ps

module slrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/slrc_front.sv
`timescale 1ns / 1ps

module slrc_front
    import slrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    slrc_in_if.sink     pixels,
    input  slrc_cfg_t   cfg,
    input  logic        queue_full,
    output logic        push,
    output slrc_entry_t push_entry
);

    localparam logic signed [V_W-1:0] NEAR_ZERO = V_W'(HALF - SCALE);

    logic                     accept;
    logic signed [DISP_W-1:0] d;
    logic signed [V_W-1:0]    v;
    logic signed [V_W-1:0]    v_round;
    logic                     v_neg;
    logic                     x_valid;
    logic [COL_W-1:0]         xr;
    logic [WEFF_W-1:0]        w_eff;
    logic                     in_row;
    check_class_t             cls;
    logic                     ram_we;
    logic                     ram_re;
    logic [DISP_W-1:0]        ram_rdata;
    logic                     s1_valid_reg;
    slrc_entry_t              s1_entry_reg;

    // handshake: stage one frees up when its item moves into the queue
    assign push         = s1_valid_reg && !queue_full;
    assign pixels.ready = !s1_valid_reg || !queue_full;
    assign accept       = pixels.valid && pixels.ready;
    assign d            = pixels.disparity_in;

    // matching right column, rounded half away from zero
    assign v       = signed'(V_W'(pixels.column) << FRACTION_BITS) - V_W'(d);
    assign v_round = v + V_W'(HALF);
    assign v_neg   = v[V_W-1];
    assign x_valid = !v_neg || (v > NEAR_ZERO);
    assign xr      = v_neg ? '0 : v_round[FRACTION_BITS +: COL_W];

    // row width clamped to the store depth
    assign w_eff  = (int'(cfg.row_width) > MAX_WIDTH) ? WEFF_W'(MAX_WIDTH)
                                                      : WEFF_W'(cfg.row_width);
    assign in_row = x_valid && (WEFF_W'(xr) < w_eff);

    // classify the check item
    always_comb
    begin
        if (d[DISP_W-1])
        begin
            cls = CLS_INVALID_IN;
        end
        else if (!cfg.check_enable)
        begin
            cls = CLS_KEEP;
        end
        else if (!in_row)
        begin
            cls = CLS_OUT_OF_ROW;
        end
        else
        begin
            cls = CLS_COMPARE;
        end
    end

    // row store: loads write, compared checks read
    assign ram_we = accept && (pixels.op == OP_LOAD) && (int'(pixels.column) < MAX_WIDTH);
    assign ram_re = accept && (pixels.op == OP_CHECK) && (cls == CLS_COMPARE);

    slrc_ram #(
        .WIDTH (DISP_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(pixels.column)),
        .wdata (pixels.disparity_in),
        .re    (ram_re),
        .raddr (ADDR_W'(xr)),
        .rdata (ram_rdata)
    );

    // stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept && (pixels.op == OP_CHECK))
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (accept && (pixels.op == OP_CHECK))
        begin
            s1_entry_reg.column     <= pixels.column;
            s1_entry_reg.disp       <= d;
            s1_entry_reg.right_disp <= '0;
            s1_entry_reg.cls        <= cls;
        end
    end

    // right disparity joins the item on its way into the queue
    always_comb
    begin
        push_entry            = s1_entry_reg;
        push_entry.right_disp = signed'(ram_rdata);
    end

endmodule

// File: rtl/slrc_queue.sv
`timescale 1ns / 1ps
`include "stereo_left_right_check_assert.svh"

module slrc_queue
    import slrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  slrc_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output slrc_entry_t head
);

    slrc_entry_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full       = (int'(count_reg) == QUEUE_DEPTH);
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `SLRC_ASSERT(a_no_overflow, push |-> (int'(count_reg) < QUEUE_DEPTH), "queue push while full")
    `SLRC_NEVER(a_no_underflow, pop && (count_reg == '0), "queue pop while empty")
    `SLRC_ASSERT(a_count_tracks, push && !pop |=> count_reg == $past(count_reg) + 1'b1, "queue count lost an item")

endmodule

// File: rtl/slrc_back.sv
`timescale 1ns / 1ps
`include "stereo_left_right_check_assert.svh"

module slrc_back
    import slrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  slrc_cfg_t   cfg,
    input  logic        head_valid,
    input  slrc_entry_t head,
    output logic        pop,
    slrc_out_if.source  results
);

    logic signed [CMP_W-1:0]  d_x;
    logic signed [CMP_W-1:0]  dr_x;
    logic signed [CMP_W-1:0]  tol_x;
    logic signed [CMP_W-1:0]  diff_x;
    logic                     fail;
    logic                     occl;
    logic signed [DISP_W-1:0] disp_next;
    status_t                  status_next;
    logic                     out_valid_reg;
    logic [COL_W-1:0]         column_reg;
    logic signed [DISP_W-1:0] disp_reg;
    status_t                  status_reg;

    // disparity compare against max difference plus half a pixel
    assign d_x    = CMP_W'(head.disp);
    assign dr_x   = CMP_W'(head.right_disp);
    assign tol_x  = (CMP_W'(cfg.max_difference) << FRACTION_BITS) + CMP_W'(HALF);
    assign diff_x = d_x - dr_x;
    assign fail   = head.right_disp[DISP_W-1] || (diff_x > tol_x) || (diff_x < -tol_x);
    assign occl   = dr_x > (d_x + tol_x);

    // result by class
    always_comb
    begin
        disp_next   = head.disp;
        status_next = STATUS_KEPT;
        case (head.cls)
            CLS_KEEP:
            begin
                status_next = STATUS_KEPT;
            end
            CLS_INVALID_IN:
            begin
                status_next = STATUS_INVALID;
            end
            CLS_OUT_OF_ROW:
            begin
                disp_next   = INVALID_DISP;
                status_next = STATUS_OCCLUSION;
            end
            default:
            begin
                if (fail)
                begin
                    disp_next   = INVALID_DISP;
                    status_next = occl ? STATUS_OCCLUSION : STATUS_MISMATCH;
                end
            end
        endcase
    end

    // output register, refilled while the sink takes the current item
    assign pop = head_valid && (!out_valid_reg || results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            column_reg <= head.column;
            disp_reg   <= disp_next;
            status_reg <= status_next;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.column_out    = column_reg;
    assign results.disparity_out = disp_reg;
    assign results.status        = status_reg;

    `SLRC_ASSERT(a_reject_marks_invalid, out_valid_reg && (status_reg == STATUS_OCCLUSION || status_reg == STATUS_MISMATCH) |-> disp_reg == INVALID_DISP, "rejected pixel not marked invalid")
    `SLRC_ASSERT(a_kept_is_valid, out_valid_reg && (status_reg == STATUS_KEPT) |-> !disp_reg[DISP_W-1], "kept pixel carries a negative disparity")

endmodule

// File: rtl/stereo_left_right_check.sv
`timescale 1ns / 1ps
// channel   role     payload
// pixels    sink     op, column, disparity_in
// results   source   column_out, disparity_out, status
// cfg       write    cfg_we, cfg_index, cfg_data
//
// one item per clock while the result sink keeps up; output stalls hold the input
// a check result passes the registered read of the row store, one queue slot and
// the output register
// loads write the row store at acceptance and give no result
// a four-entry queue between classification and compare absorbs output stalls
// no clearing pass after reset: row store entries are undefined until loaded

module stereo_left_right_check
    import slrc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    slrc_in_if.sink                pixels,
    slrc_out_if.source             results,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    slrc_cfg_t   cfg_reg;
    logic        queue_full;
    logic        push;
    slrc_entry_t push_entry;
    logic        pop;
    logic        head_valid;
    slrc_entry_t head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_enable   <= 1'b1;
            cfg_reg.max_difference <= MD_W'(1);
            cfg_reg.row_width      <= ROW_W'(2048);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHECK_ENABLE:   cfg_reg.check_enable   <= cfg_data[0];
                CFG_MAX_DIFFERENCE: cfg_reg.max_difference <= cfg_data[MD_W-1:0];
                CFG_ROW_WIDTH:      cfg_reg.row_width      <= cfg_data[ROW_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // classification and row store
    slrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pixels),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // decoupling queue
    slrc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // compare and result register
    slrc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .results    (results)
    );

endmodule

// File: bench/tb_stereo_left_right_check.sv
`timescale 1ns / 1ps

module tb_stereo_left_right_check;
    import slrc_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        logic [COL_W-1:0]         column;
        logic signed [DISP_W-1:0] disparity;
        status_t                  status;
    } checked_pixel_t;

    // predicts checked pixels and compares them with what the block returns
    class disparity_scoreboard;
        logic signed [DISP_W-1:0] right_row [MAX_WIDTH];
        bit                       loaded [MAX_WIDTH];
        bit                       check_on;
        logic [MD_W-1:0]          max_diff;
        logic [ROW_W-1:0]         width;
        checked_pixel_t           expected_pixels [$];
        int                       errors;

        function new();
            check_on = 1'b1;
            max_diff = 1;
            width    = ROW_W'(MAX_WIDTH);
            errors   = 0;
            foreach (loaded[i])
            begin
                loaded[i]    = 1'b0;
                right_row[i] = '0;
            end
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_CHECK_ENABLE:   check_on = value[0];
                CFG_MAX_DIFFERENCE: max_diff = value[MD_W-1:0];
                CFG_ROW_WIDTH:      width    = value[ROW_W-1:0];
                default: ;
            endcase
        endfunction

        // row width clamped to the store depth
        function int row_limit();
            return (width > MAX_WIDTH) ? MAX_WIDTH : int'(width);
        endfunction

        // right column a check item maps to; 1 when the check reads the store
        function bit matched_column(logic [COL_W-1:0] col,
                                    logic signed [DISP_W-1:0] disp,
                                    output int xr);
            int d;
            int v;
            d = disp;
            v = int'(col) * SCALE - d;
            // round half away from zero
            if (v >= 0)
                xr = (v + HALF) / SCALE;
            else
                xr = -((-v + HALF) / SCALE);
            return check_on && (d >= 0) && (xr >= 0) && (xr < row_limit());
        endfunction

        function void note_pixel(op_t op, logic [COL_W-1:0] col,
                                 logic signed [DISP_W-1:0] disp);
            checked_pixel_t px;
            int xr;
            int d;
            int dr;
            int diff;
            int tol;
            if (op == OP_LOAD)
            begin
                right_row[col] = disp;
                loaded[col]    = 1'b1;
                return;
            end
            d            = disp;
            tol          = int'(max_diff) * SCALE + HALF;
            px.column    = col;
            px.disparity = disp;
            px.status    = STATUS_KEPT;
            if (d < 0)
                px.status = STATUS_INVALID;
            else if (check_on)
            begin
                if (!matched_column(col, disp, xr))
                begin
                    px.status    = STATUS_OCCLUSION;
                    px.disparity = INVALID_DISP;
                end
                else
                begin
                    dr   = right_row[xr];
                    diff = (d > dr) ? d - dr : dr - d;
                    if (dr < 0 || diff > tol)
                    begin
                        px.status    = (dr > d + tol) ? STATUS_OCCLUSION : STATUS_MISMATCH;
                        px.disparity = INVALID_DISP;
                    end
                end
            end
            expected_pixels = {expected_pixels, px};
        endfunction

        function void check_result(logic [COL_W-1:0] col,
                                   logic signed [DISP_W-1:0] disp,
                                   logic [1:0] st);
            checked_pixel_t px;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual col %0d disp %0d st %0d",
                         $time, col, disp, st);
                errors++;
                return;
            end
            px = expected_pixels.pop_front();
            if (px.column !== col)
            begin
                $display("%0t: column mismatch, expected %0d, actual %0d",
                         $time, px.column, col);
                errors++;
            end
            if (px.disparity !== disp)
            begin
                $display("%0t: disparity mismatch at col %0d, expected %0d, actual %0d",
                         $time, px.column, px.disparity, disp);
                errors++;
            end
            if (2'(px.status) !== st)
            begin
                $display("%0t: status mismatch at col %0d, expected %0d, actual %0d",
                         $time, px.column, px.status, st);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    slrc_in_if  pixels ();
    slrc_out_if results ();

    disparity_scoreboard board;
    bit                  steady;
    int                  items_sent;
    int                  cycle_count = 0;

    stereo_left_right_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // idle cycles before an item, none during steady stretches
    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 3);
    endfunction

    // right disparity, sometimes invalid
    function automatic logic signed [DISP_W-1:0] random_right();
        int r;
        case ($urandom_range(0, 9))
            0:       r = -int'($urandom_range(1, 16));
            1, 2:    r = $urandom_range(0, 4095);
            default: r = $urandom_range(0, 1023);
        endcase
        return DISP_W'(r);
    endfunction

    // one pixel item on the input channel, entered and left at a falling edge
    task automatic send_item(op_t op, logic [COL_W-1:0] col,
                             logic signed [DISP_W-1:0] disp);
        int gap;
        gap = draw_gap();
        if ($urandom_range(0, 39) == 0)
            steady = !steady;
        if (gap > 0)
        begin
            pixels.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixels.valid        <= 1'b1;
        pixels.op           <= op;
        pixels.column       <= col;
        pixels.disparity_in <= disp;
        @(posedge clk);
        while (!pixels.ready)
            @(posedge clk);
        board.note_pixel(op, col, disp);
        items_sent++;
        @(negedge clk);
    endtask

    // check item, loading its matched column first if it was never loaded
    task automatic send_check(logic [COL_W-1:0] col, logic signed [DISP_W-1:0] disp);
        int xr;
        if (board.matched_column(col, disp, xr) && !board.loaded[xr])
            send_item(OP_LOAD, COL_W'(xr), random_right());
        send_item(OP_CHECK, col, disp);
    endtask

    // wait for every expected pixel, then let the pipeline settle
    task automatic wait_idle();
        pixels.valid <= 1'b0;
        while (board.expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        board.write_register(idx, CFG_DATA_W'(value));
        @(negedge clk);
    endtask

    // one setting: load a window of the row, then mostly consistent checks
    task automatic run_phase(int en, int md, int w, int count);
        int weff;
        int len;
        int base;
        int start;
        int kind;
        int xr;
        int dr;
        int spread;
        int d;
        int c;
        write_register(CFG_CHECK_ENABLE, en);
        write_register(CFG_MAX_DIFFERENCE, md);
        write_register(CFG_ROW_WIDTH, w);
        weff = board.row_limit();
        len  = $urandom_range(8, 48);
        if (weff > 0 && len > weff)
            len = weff;
        if (weff == 0)
            base = $urandom_range(0, MAX_WIDTH - len);
        else
            base = (weff > len) ? $urandom_range(0, weff - len) : 0;
        start = items_sent;
        for (int i = 0; i < len; i++)
            send_item(OP_LOAD, COL_W'(base + i), random_right());
        while (items_sent - start < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                // left disparity near the right one it should match
                xr     = base + $urandom_range(0, len - 1);
                dr     = board.right_row[xr];
                if (dr < 0)
                    dr = 0;
                spread = md * SCALE + HALF + 24;
                d      = dr + $urandom_range(0, 2 * spread) - spread;
                d      = (d < 0) ? 0 : (d > 4095 ? 4095 : d);
                c      = xr + (d + HALF) / SCALE + $urandom_range(0, 2) - 1;
                c      = (c < 0) ? 0 : (c > MAX_WIDTH - 1 ? MAX_WIDTH - 1 : c);
                send_check(COL_W'(c), DISP_W'(d));
            end
            else if (kind < 80)
                send_check(COL_W'($urandom_range(0, MAX_WIDTH - 1)),
                           DISP_W'(-int'($urandom_range(1, 16))));
            else if (kind < 90)
                send_item(OP_LOAD, COL_W'(base + $urandom_range(0, len - 1)),
                          random_right());
            else
                send_check(COL_W'($urandom_range(0, MAX_WIDTH - 1)),
                           DISP_W'($urandom_range(0, 4095)));
        end
        wait_idle();
    endtask

    // result side: random stalls, compare at each accepted item
    initial
    begin
        int gap;
        results.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                results.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            results.ready <= 1'b1;
            @(posedge clk);
            while (!results.valid)
                @(posedge clk);
            board.check_result(results.column_out, results.disparity_out, results.status);
            @(negedge clk);
        end
    end

    // stimulus
    initial
    begin
        board               = new();
        steady              = 1'b0;
        items_sent          = 0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_CHECK_ENABLE;
        cfg_data            = '0;
        pixels.valid        = 1'b0;
        pixels.op           = OP_LOAD;
        pixels.column       = '0;
        pixels.disparity_in = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items at the reset setting
        send_item(OP_LOAD, 0, 0);
        send_item(OP_LOAD, 2047, 4095);
        send_item(OP_LOAD, 10, 32);
        send_item(OP_LOAD, 5, -16);
        send_check(0, 0);
        send_check(12, 32);
        send_check(11, 24);
        // tolerance edge: a difference of 24 is kept, 25 is not
        send_check(10, 8);
        send_check(10, 7);
        // rounding near zero: one side maps below the row, the other to column 0
        send_check(0, 8);
        send_check(0, 7);
        // right disparity far larger than the left one, then a match far below the row
        send_check(2047, 0);
        send_check(0, 4095);
        // already invalid on the left
        send_check(3, -16);
        send_check(2047, -1);
        // invalid right disparity
        send_check(6, 16);
        // too far apart with the right one smaller
        send_check(14, 60);
        send_check(2047, 4095);
        wait_idle();

        // settings including the extremes, then random ones
        run_phase(0, 255, 1, 90);
        run_phase(1, 0, 2048, 100);
        run_phase(1, 255, 4095, 100);
        run_phase(1, 1, 0, 60);
        run_phase(1, 0, 1, 60);
        run_phase(1, 2, 64, 100);
        repeat (5)
            run_phase($urandom_range(0, 5) != 0,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 8),
                      $urandom_range(1, 4095), 100);

        if (board.errors == 0 && board.expected_pixels.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
